// File: sv/assert_macros.svh
// Assertion macros shared by the gate RTL.
// Needs no other file; the SYNTH macro removes every check for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, expr, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (expr)) else $error(msg);
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk_sig, rst_sig, expr, msg)
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)
`endif
`endif

// File: sv/mng_pkg.sv
// Types, constants and the sequencer schedule of the Mahalanobis nearest gate.
// Used by mng_mac, mng_seq and mahalanobis_nearest_gate; depends on nothing.
`default_nettype none

package mng_pkg;

  localparam int MAX_DETECTIONS = 256;

  localparam int POS_W  = 20;  // Q12.8 positions
  localparam int COV_W  = 16;  // Q8.8 covariance terms
  localparam int GATE_W = 16;  // Q8.8 gate threshold
  localparam int IDX_W  = 8;
  localparam int DIFF_W = 21;  // innovation, Q13.8
  localparam int OP_W   = 22;  // multiplier operand width
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = 60;  // numerator stays below 2^58 in magnitude
  localparam int DET_W  = 34;
  localparam int LIM_W  = 50;
  localparam int MID_W  = 39;  // intermediate terms u and v
  localparam int SPLIT  = 20;  // low half width when an operand is split
  localparam int BEST_W = 61;
  localparam int STEP_W = 4;

  localparam logic [GATE_W-1:0] GATE_RESET = 16'd2360;
  localparam logic [BEST_W-1:0] BEST_ONES  = '1;
  localparam logic [STEP_W-1:0] LAST_STEP  = 4'd13;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DET  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FIN
  } state_t;

  // Operand pairs fed to the shared multiplier.
  typedef enum logic [3:0] {
    OP_AC,    // cov_xx * cov_yy
    OP_BB,    // cov_xy * cov_xy
    OP_CDX,   // cov_yy * dx
    OP_B2DY,  // 2 cov_xy * dy
    OP_TDL,   // threshold * low half of det
    OP_TDH,   // threshold * high half of det
    OP_ADY,   // cov_xx * dy
    OP_DXUL,  // dx * low half of u
    OP_DXUH,  // dx * high half of u
    OP_DYVL,  // dy * low half of v
    OP_DYVH   // dy * high half of v
  } op_t;

  typedef struct packed {
    logic issue;
    logic neg;
    logic sh;
    logic clr;
  } mac_cmd_t;

  typedef struct packed {
    op_t      op;
    mac_cmd_t cmd;
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic cap_det;
    logic cap_u;
    logic cap_lim;
    logic cap_v;
    logic cap_gate;
    logic upd_best;
    logic fin;
    logic idle;
  } seq_ctrl_t;

  typedef struct packed {
    logic                     cmd;
    logic signed [POS_W-1:0]  pred_x;
    logic signed [POS_W-1:0]  pred_y;
    logic        [COV_W-1:0]  cov_xx;
    logic signed [COV_W-1:0]  cov_xy;
    logic        [COV_W-1:0]  cov_yy;
    logic signed [POS_W-1:0]  det_x;
    logic signed [POS_W-1:0]  det_y;
    logic        [IDX_W-1:0]  det_index;
    logic                     det_last;
  } in_word_t;

  typedef struct packed {
    logic             match_found;
    logic [IDX_W-1:0] match_index;
  } out_word_t;

  function automatic uop_t mk_uop(input op_t op, input logic neg, input logic sh,
                                  input logic clr);
    uop_t u;
    u.op        = op;
    u.cmd.issue = 1'b1;
    u.cmd.neg   = neg;
    u.cmd.sh    = sh;
    u.cmd.clr   = clr;
    return u;
  endfunction

  // A product issued at a step is held in the product register and then added into
  // the accumulator, so a chain is captured only after its last product is added.
  function automatic seq_ctrl_t step_ctrl(input logic [STEP_W-1:0] step);
    seq_ctrl_t c;
    c = '0;
    case (step)
      4'd0:  c.uop = mk_uop(OP_AC,   1'b0, 1'b0, 1'b1);
      4'd1:  c.uop = mk_uop(OP_BB,   1'b1, 1'b0, 1'b0);
      4'd2:  c.uop = mk_uop(OP_CDX,  1'b0, 1'b0, 1'b1);
      4'd3: begin
        c.uop     = mk_uop(OP_B2DY, 1'b1, 1'b0, 1'b0);
        c.cap_det = 1'b1;
      end
      4'd4:  c.uop = mk_uop(OP_TDL,  1'b0, 1'b0, 1'b1);
      4'd5: begin
        c.uop   = mk_uop(OP_TDH, 1'b0, 1'b1, 1'b0);
        c.cap_u = 1'b1;
      end
      4'd6:  c.uop = mk_uop(OP_ADY,  1'b0, 1'b0, 1'b1);
      4'd7: begin
        c.uop     = mk_uop(OP_DXUL, 1'b0, 1'b0, 1'b1);
        c.cap_lim = 1'b1;
      end
      4'd8: begin
        c.uop   = mk_uop(OP_DXUH, 1'b0, 1'b1, 1'b0);
        c.cap_v = 1'b1;
      end
      4'd9:  c.uop = mk_uop(OP_DYVL, 1'b0, 1'b0, 1'b0);
      4'd10: c.uop = mk_uop(OP_DYVH, 1'b0, 1'b1, 1'b0);
      4'd12: c.cap_gate = 1'b1;
      4'd13: c.upd_best = 1'b1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/mng_mac.sv
// Shared multiply-accumulate unit: registered product, then signed accumulate.
// Depends on mng_pkg.
`default_nettype none

module mng_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mng_pkg::mac_cmd_t                   cmd,
  input  wire logic signed [mng_pkg::OP_W-1:0]     opa,
  input  wire logic signed [mng_pkg::OP_W-1:0]     opb,
  output logic signed      [mng_pkg::ACC_W-1:0]    acc
);

  logic signed [mng_pkg::PROD_W-1:0] prod;
  logic                              p_valid;
  logic                              p_neg;
  logic                              p_sh;
  logic                              p_clr;
  logic signed [mng_pkg::ACC_W-1:0]  term;
  logic signed [mng_pkg::ACC_W-1:0]  shifted;
  logic signed [mng_pkg::ACC_W-1:0]  base;
  logic signed [mng_pkg::ACC_W-1:0]  acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= cmd.issue;
    end
    prod  <= opa * opb;
    p_neg <= cmd.neg;
    p_sh  <= cmd.sh;
    p_clr <= cmd.clr;
  end

  always_comb begin
    term     = {{(mng_pkg::ACC_W - mng_pkg::PROD_W){prod[mng_pkg::PROD_W-1]}}, prod};
    shifted  = p_sh ? (term <<< mng_pkg::SPLIT) : term;
    base     = p_clr ? '0 : acc;
    acc_next = p_neg ? (base - shifted) : (base + shifted);
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/mng_seq.sv
// Sequencer of the gate: idle, a fixed schedule of steps, then the finish step.
// Depends on mng_pkg for the state type and the step schedule.
`default_nettype none

module mng_seq (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               fin_go,
  output mng_pkg::seq_ctrl_t      ctrl
);

  mng_pkg::state_t               state;
  mng_pkg::state_t               state_next;
  logic [mng_pkg::STEP_W-1:0]    step;
  logic [mng_pkg::STEP_W-1:0]    step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mng_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = '0;
    case (state)
      mng_pkg::ST_IDLE: begin
        if (start) begin
          state_next = mng_pkg::ST_CALC;
        end
      end
      mng_pkg::ST_CALC: begin
        if (step == mng_pkg::LAST_STEP) begin
          state_next = mng_pkg::ST_FIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      mng_pkg::ST_FIN: begin
        if (fin_go) begin
          state_next = mng_pkg::ST_IDLE;
        end
      end
      default: state_next = mng_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      mng_pkg::ST_IDLE: ctrl.idle = 1'b1;
      mng_pkg::ST_CALC: ctrl = mng_pkg::step_ctrl(step);
      mng_pkg::ST_FIN:  ctrl.fin = 1'b1;
      default:          ctrl = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/mahalanobis_nearest_gate.sv
// Nearest-neighbor Mahalanobis gate for one track; uses mng_pkg, mng_seq, mng_mac.
// A load word is taken while the sequencer stays idle. A detection word runs 14
// schedule steps and one finish step on one shared multiplier: the next word is
// accepted after the finish step, which writes the report word on a frame's last detection.
// Synchronous active-high reset clears the track, the search and the output,
// and sets the gate threshold to 9.22 (Q8.8 value 2360).
`default_nettype none
`include "assert_macros.svh"

module mahalanobis_nearest_gate #(
  parameter int MAX_DETECTIONS = mng_pkg::MAX_DETECTIONS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // gate threshold register
  input  wire logic                              cfg_wr_en,
  input  wire logic [mng_pkg::GATE_W-1:0]        cfg_wr_data,
  // input words
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire mng_pkg::in_word_t                 in_data,
  // report words
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output mng_pkg::out_word_t                     out_data
);

  // Detection indexes are compared against the limit at 13 bits, which holds
  // limits up to 8191.
  localparam int                 LIMIT_W   = 13;
  localparam logic [LIMIT_W-1:0] IDX_LIMIT = LIMIT_W'(MAX_DETECTIONS);

  // Configuration and track state.
  logic        [mng_pkg::GATE_W-1:0]  gate_threshold;
  logic signed [mng_pkg::POS_W-1:0]   track_pred_x;
  logic signed [mng_pkg::POS_W-1:0]   track_pred_y;
  logic        [mng_pkg::COV_W-1:0]   track_cov_xx;
  logic signed [mng_pkg::COV_W-1:0]   track_cov_xy;
  logic        [mng_pkg::COV_W-1:0]   track_cov_yy;

  // Search state over one frame.
  logic        [mng_pkg::BEST_W-1:0]  best_numerator;
  logic        [mng_pkg::IDX_W-1:0]   best_index;
  logic                               any_found;

  // Per-detection working registers.
  logic signed [mng_pkg::DIFF_W-1:0]  dx;
  logic signed [mng_pkg::DIFF_W-1:0]  dy;
  logic        [mng_pkg::IDX_W-1:0]   cur_index;
  logic                               cur_last;
  logic signed [mng_pkg::DET_W-1:0]   det_val;
  logic signed [mng_pkg::LIM_W-1:0]   lim_val;
  logic signed [mng_pkg::MID_W-1:0]   u_val;
  logic signed [mng_pkg::MID_W-1:0]   v_val;
  logic        [mng_pkg::BEST_W-1:0]  num_val;
  logic                               gate_ok;

  mng_pkg::seq_ctrl_t                 ctrl;
  logic signed [mng_pkg::OP_W-1:0]    opa;
  logic signed [mng_pkg::OP_W-1:0]    opb;
  logic signed [mng_pkg::ACC_W-1:0]   acc;

  logic in_fire;
  logic start;
  logic load;
  logic out_free;
  logic fin_go;
  logic rep_write;
  logic det_pos;
  logic idx_ok;
  logic num_lt_lim;

  // Input side is open only while the sequencer is idle. A pending report word
  // does not hold the input: the output register parts the two sides.
  assign in_stall = !ctrl.idle;
  assign in_fire  = in_valid && ctrl.idle;
  assign start    = in_fire && (in_data.cmd == mng_pkg::CMD_DET);
  assign load     = in_fire && (in_data.cmd == mng_pkg::CMD_LOAD);

  // The finish step waits only when this detection closes the frame and the
  // output register still holds a word that is not being taken.
  assign out_free  = !out_valid || !out_stall;
  assign fin_go    = !cur_last || out_free;
  assign rep_write = ctrl.fin && cur_last && out_free;

  mng_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .fin_go (fin_go),
    .ctrl   (ctrl)
  );

  // Operand selection for the shared multiplier. Wide values (det, u and v)
  // are split into an unsigned low half and a signed high half; the unit
  // shifts the high partial product left by the low half's width.
  always_comb begin
    case (ctrl.uop.op)
      mng_pkg::OP_AC: begin
        opa = $signed(mng_pkg::OP_W'(track_cov_xx));
        opb = $signed(mng_pkg::OP_W'(track_cov_yy));
      end
      mng_pkg::OP_BB: begin
        opa = mng_pkg::OP_W'(track_cov_xy);
        opb = mng_pkg::OP_W'(track_cov_xy);
      end
      mng_pkg::OP_CDX: begin
        opa = $signed(mng_pkg::OP_W'(track_cov_yy));
        opb = mng_pkg::OP_W'(dx);
      end
      mng_pkg::OP_B2DY: begin
        opa = mng_pkg::OP_W'(track_cov_xy) <<< 1;
        opb = mng_pkg::OP_W'(dy);
      end
      mng_pkg::OP_TDL: begin
        opa = $signed(mng_pkg::OP_W'(gate_threshold));
        opb = $signed(mng_pkg::OP_W'(det_val[mng_pkg::SPLIT-1:0]));
      end
      mng_pkg::OP_TDH: begin
        opa = $signed(mng_pkg::OP_W'(gate_threshold));
        opb = mng_pkg::OP_W'($signed(det_val[mng_pkg::DET_W-1:mng_pkg::SPLIT]));
      end
      mng_pkg::OP_ADY: begin
        opa = $signed(mng_pkg::OP_W'(track_cov_xx));
        opb = mng_pkg::OP_W'(dy);
      end
      mng_pkg::OP_DXUL: begin
        opa = mng_pkg::OP_W'(dx);
        opb = $signed(mng_pkg::OP_W'(u_val[mng_pkg::SPLIT-1:0]));
      end
      mng_pkg::OP_DXUH: begin
        opa = mng_pkg::OP_W'(dx);
        opb = mng_pkg::OP_W'($signed(u_val[mng_pkg::MID_W-1:mng_pkg::SPLIT]));
      end
      mng_pkg::OP_DYVL: begin
        opa = mng_pkg::OP_W'(dy);
        opb = $signed(mng_pkg::OP_W'(v_val[mng_pkg::SPLIT-1:0]));
      end
      mng_pkg::OP_DYVH: begin
        opa = mng_pkg::OP_W'(dy);
        opb = mng_pkg::OP_W'($signed(v_val[mng_pkg::MID_W-1:mng_pkg::SPLIT]));
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // The schedule builds, in order:
  //   det = cov_xx*cov_yy - cov_xy^2
  //   u   = cov_yy*dx - 2*cov_xy*dy
  //   lim = threshold * det
  //   v   = cov_xx*dy
  //   N   = dx*u + dy*v  (the numerator of the normalized innovation squared)
  mng_mac u_mac (
    .clk (clk),
    .rst (rst),
    .cmd (ctrl.uop.cmd),
    .opa (opa),
    .opb (opb),
    .acc (acc)
  );

  // Gate test on the finished numerator. Comparing N with threshold * det
  // replaces the division by the determinant; a non-positive determinant or
  // an index beyond the list size rejects the detection outright.
  assign det_pos    = !det_val[mng_pkg::DET_W-1] && (det_val != '0);
  assign idx_ok     = {{(LIMIT_W - mng_pkg::IDX_W){1'b0}}, cur_index} < IDX_LIMIT;
  assign num_lt_lim = acc < mng_pkg::ACC_W'(lim_val);

  // Working registers; they need no reset since every detection rebuilds them.
  always_ff @(posedge clk) begin
    if (start) begin
      dx        <= mng_pkg::DIFF_W'(in_data.det_x) - mng_pkg::DIFF_W'(track_pred_x);
      dy        <= mng_pkg::DIFF_W'(in_data.det_y) - mng_pkg::DIFF_W'(track_pred_y);
      cur_index <= in_data.det_index;
    end
    if (ctrl.cap_det) begin
      det_val <= $signed(acc[mng_pkg::DET_W-1:0]);
    end
    if (ctrl.cap_u) begin
      u_val <= $signed(acc[mng_pkg::MID_W-1:0]);
    end
    if (ctrl.cap_lim) begin
      lim_val <= $signed(acc[mng_pkg::LIM_W-1:0]);
    end
    if (ctrl.cap_v) begin
      v_val <= $signed(acc[mng_pkg::MID_W-1:0]);
    end
    if (ctrl.cap_gate) begin
      gate_ok <= det_pos && idx_ok && !acc[mng_pkg::ACC_W-1] && num_lt_lim;
      num_val <= mng_pkg::BEST_W'(acc[mng_pkg::ACC_W-2:0]);
    end
  end

  // The last mark is control: the finish step reads it, so it is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_last <= 1'b0;
    end else if (start) begin
      cur_last <= in_data.det_last;
    end
  end

  // Threshold, track and search state. A load word and a written report
  // both restart the search; a strictly smaller numerator replaces the best,
  // so on a tie the earlier detection stays.
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_threshold <= mng_pkg::GATE_RESET;
      track_pred_x   <= '0;
      track_pred_y   <= '0;
      track_cov_xx   <= '0;
      track_cov_xy   <= '0;
      track_cov_yy   <= '0;
      best_numerator <= mng_pkg::BEST_ONES;
      best_index     <= '0;
      any_found      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gate_threshold <= cfg_wr_data;
      end
      if (load) begin
        track_pred_x   <= in_data.pred_x;
        track_pred_y   <= in_data.pred_y;
        track_cov_xx   <= in_data.cov_xx;
        track_cov_xy   <= in_data.cov_xy;
        track_cov_yy   <= in_data.cov_yy;
      end
      if (load || rep_write) begin
        best_numerator <= mng_pkg::BEST_ONES;
        best_index     <= '0;
        any_found      <= 1'b0;
      end else if (ctrl.upd_best && gate_ok && (num_val < best_numerator)) begin
        best_numerator <= num_val;
        best_index     <= cur_index;
        any_found      <= 1'b1;
      end
    end
  end

  // Output register: holds one report word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rep_write) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rep_write) begin
      out_data.match_found <= any_found;
      out_data.match_index <= any_found ? best_index : '0;
    end
  end

  // A report written in the finish step must be on the output the next cycle.
  `ASSERT_NEXT(a_report_shown, clk, rst, rep_write, out_valid, "report word was not presented")
  // An accepted detection closes the input until its schedule has run.
  `ASSERT_NEXT(a_busy_after_start, clk, rst, start, in_stall, "input open during a detection")
  // A report without a match carries index zero.
  `ASSERT_ALWAYS(a_no_match_index, clk, rst, !out_valid || out_data.match_found || (out_data.match_index == '0), "report without a match has a nonzero index")
  // Once a detection is gated the best numerator has left its cleared value.
  `ASSERT_ALWAYS(a_found_has_best, clk, rst, !any_found || (best_numerator != mng_pkg::BEST_ONES), "match flagged with a cleared best numerator")

endmodule

`default_nettype wire
